### hdl/rhc_pkg.sv
`default_nettype none

package rhc_pkg;

  // Channel width and hue scaling.
  localparam int CB      = 8;
  localparam int HFB     = 6;
  localparam int HUE_W   = 15;
  localparam int CMAX    = (1 << CB) - 1;

  // Hue constants in units of 1/2^HFB degree.
  localparam int HUE_SIXTH      = 60 << HFB;
  localparam int HUE_THIRD      = 120 << HFB;
  localparam int HUE_TWO_THIRDS = 240 << HFB;
  localparam int HUE_FULL       = 360 << HFB;

  // Quotient bits needed by the larger of the two divisions (hue: up to HUE_SIXTH).
  localparam int QBITS  = $clog2(HUE_SIXTH + 1);
  // Working width of a division lane: holds both numerators and the shifted divisors.
  localparam int NUM_W  = $clog2(CMAX * HUE_SIXTH + 1);
  localparam int DSH_W  = CB + QBITS - 1;
  localparam int LANE_W = (NUM_W > DSH_W) ? NUM_W : DSH_W;

  // Signed width for the hue sum before wrapping.
  localparam int HSUM_W = $clog2(HUE_FULL) + 2;

  typedef enum logic [1:0] {
    SEC_RED   = 2'd0,
    SEC_GREEN = 2'd1,
    SEC_BLUE  = 2'd2
  } sector_t;

  typedef struct packed {
    logic [LANE_W-1:0] rem;
    logic [LANE_W-1:0] dsh;
    logic [QBITS-1:0]  quo;
  } lane_t;

  typedef struct packed {
    logic [CB-1:0] bright;
    sector_t       sec;
    logic          neg;
    logic          zero_hue;
    logic          zero_sat;
  } tag_t;

  typedef struct packed {
    lane_t sat;
    lane_t hue;
    tag_t  tag;
  } stage_t;

endpackage

`default_nettype wire

### hdl/rhc_front.sv
`default_nettype none

module rhc_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                acc,
  input  wire logic [rhc_pkg::CB-1:0] red,
  input  wire logic [rhc_pkg::CB-1:0] green,
  input  wire logic [rhc_pkg::CB-1:0] blue,
  output logic                     vld,
  output rhc_pkg::stage_t          stg
);
  import rhc_pkg::*;

  logic [CB-1:0]     mx;
  logic [CB-1:0]     mn;
  logic [CB-1:0]     delta;
  logic [CB:0]       diff;
  logic [CB-1:0]     mag;
  sector_t           sec;
  stage_t            stg_nxt;
  logic              vld_r;
  stage_t            stg_r;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;

    // The first channel that holds the maximum picks the sector.
    if (red >= mx) begin
      sec  = SEC_RED;
      diff = {1'b0, green} - {1'b0, blue};
    end else if (green >= mx) begin
      sec  = SEC_GREEN;
      diff = {1'b0, blue} - {1'b0, red};
    end else begin
      sec  = SEC_BLUE;
      diff = {1'b0, red} - {1'b0, green};
    end
    mag = diff[CB] ? CB'(-diff) : diff[CB-1:0];

    stg_nxt.sat.rem = LANE_W'(delta) * LANE_W'(CMAX);
    stg_nxt.sat.dsh = LANE_W'(mx) << (QBITS - 1);
    stg_nxt.sat.quo = '0;
    stg_nxt.hue.rem = LANE_W'(mag) * LANE_W'(HUE_SIXTH);
    stg_nxt.hue.dsh = LANE_W'(delta) << (QBITS - 1);
    stg_nxt.hue.quo = '0;
    stg_nxt.tag.bright   = mx;
    stg_nxt.tag.sec      = sec;
    stg_nxt.tag.neg      = diff[CB];
    stg_nxt.tag.zero_hue = (delta == '0);
    stg_nxt.tag.zero_sat = (mx == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

  assign vld = vld_r;
  assign stg = stg_r;

endmodule

`default_nettype wire

### hdl/rhc_cell.sv
`default_nettype none

module rhc_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            vld_in,
  input  rhc_pkg::stage_t      stg_in,
  output logic                 vld_out,
  output rhc_pkg::stage_t      stg_out
);
  import rhc_pkg::*;

  logic   vld_r;
  stage_t stg_r;
  stage_t stg_nxt;

  // One restoring step on a lane: trial subtract, then halve the divisor.
  function automatic lane_t div_step(input lane_t l);
    lane_t o;
    logic  ge;
    ge    = (l.rem >= l.dsh);
    o.rem = ge ? (l.rem - l.dsh) : l.rem;
    o.dsh = l.dsh >> 1;
    o.quo = {l.quo[QBITS-2:0], ge};
    return o;
  endfunction

  always_comb begin
    stg_nxt     = stg_in;
    stg_nxt.sat = div_step(stg_in.sat);
    stg_nxt.hue = div_step(stg_in.hue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

  assign vld_out = vld_r;
  assign stg_out = stg_r;

endmodule

`default_nettype wire

### hdl/rhc_back.sv
`default_nettype none

module rhc_back (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     vld_in,
  input  rhc_pkg::stage_t               stg_in,
  output logic                          vld,
  output logic [rhc_pkg::HUE_W-1:0]     hue,
  output logic [rhc_pkg::CB-1:0]        sat,
  output logic [rhc_pkg::CB-1:0]        bright
);
  import rhc_pkg::*;

  logic signed [HSUM_W-1:0] offs;
  logic signed [HSUM_W-1:0] qs;
  logic signed [HSUM_W-1:0] hsum;
  logic [HUE_W-1:0]         hue_nxt;
  logic [CB-1:0]            sat_nxt;
  logic                     vld_r;
  logic [HUE_W-1:0]         hue_r;
  logic [CB-1:0]            sat_r;
  logic [CB-1:0]            bright_r;

  always_comb begin
    case (stg_in.tag.sec)
      SEC_RED:   offs = '0;
      SEC_GREEN: offs = HSUM_W'(HUE_THIRD);
      SEC_BLUE:  offs = HSUM_W'(HUE_TWO_THIRDS);
      default:   offs = '0;
    endcase
    qs   = HSUM_W'(stg_in.hue.quo);
    hsum = stg_in.tag.neg ? (offs - qs) : (offs + qs);
    // A truncated quotient of zero leaves the sum at zero, so no wrap there.
    if (hsum < 0) hsum = hsum + HSUM_W'(HUE_FULL);
    hue_nxt = stg_in.tag.zero_hue ? '0 : hsum[HUE_W-1:0];
    sat_nxt = stg_in.tag.zero_sat ? '0 : stg_in.sat.quo[CB-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    hue_r    <= hue_nxt;
    sat_r    <= sat_nxt;
    bright_r <= stg_in.tag.bright;
  end

  assign vld    = vld_r;
  assign hue    = hue_r;
  assign sat    = sat_r;
  assign bright = bright_r;

endmodule

`default_nettype wire

### hdl/rgb_to_hsv_convert.sv
`default_nettype none

// RGB to HSV converter for 8-bit channels. A pixel beat is taken at every
// clock edge where start is high; busy is always low, so a new pixel may be
// presented in every cycle and the block sustains one pixel per clock. Each
// result appears on the out_ ports for exactly one cycle, marked by
// out_valid, once its pixel has passed the front end, which finds the
// maximum, minimum and sector and forms the two numerators, the row of
// division cells, and the back end, which assembles the hue and registers
// the outputs. The receiver cannot stall the block, so it must take every
// result in the cycle it is shown. Brightness is the largest channel,
// saturation is floor(delta * 255 / max), and hue is in units of 1/64
// degree, 0 to 23039, with black and grey pixels giving a hue of zero.

module rgb_to_hsv_convert (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [rhc_pkg::CB-1:0]   in_red,
  input  wire logic [rhc_pkg::CB-1:0]   in_green,
  input  wire logic [rhc_pkg::CB-1:0]   in_blue,
  output logic                          out_valid,
  output logic [rhc_pkg::HUE_W-1:0]     out_hue,
  output logic [rhc_pkg::CB-1:0]        out_saturation,
  output logic [rhc_pkg::CB-1:0]        out_brightness
);
  import rhc_pkg::*;

  // Row of QBITS cells; stage 0 is the front end's output register and
  // stage k the output of cell k-1. Both divisions share each cell: the
  // saturation lane divides delta * 255 by max, the hue lane divides
  // |difference| * 3840 by delta, and each cell settles one quotient bit of
  // each, most significant first.
  logic   vld_s [QBITS+1];
  stage_t stg_s [QBITS+1];

  // The block never refuses a pixel.
  assign busy = 1'b0;

  rhc_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (start && !busy),
    .red   (in_red),
    .green (in_green),
    .blue  (in_blue),
    .vld   (vld_s[0]),
    .stg   (stg_s[0])
  );

  for (genvar k = 0; k < QBITS; k++) begin : g_cell
    rhc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .vld_in  (vld_s[k]),
      .stg_in  (stg_s[k]),
      .vld_out (vld_s[k+1]),
      .stg_out (stg_s[k+1])
    );
  end

  // Sector offset, sign and the black and grey cases are applied here.
  rhc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_in (vld_s[QBITS]),
    .stg_in (stg_s[QBITS]),
    .vld    (out_valid),
    .hue    (out_hue),
    .sat    (out_saturation),
    .bright (out_brightness)
  );

`ifndef SYNTHESIS
  // The wrap into the full circle must never leave a hue of 360 degrees or more.
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue < HUE_W'(HUE_FULL)))
    else $error("hue out of range");

  // A black pixel gives zero saturation and zero hue.
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_brightness == '0)) |-> ((out_saturation == '0) && (out_hue == '0)))
    else $error("black pixel with non-zero hue or saturation");

  // Zero saturation means a grey pixel, whose hue must be zero.
  a_grey: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_saturation == '0)) |-> (out_hue == '0))
    else $error("grey pixel with non-zero hue");

  // A result beat is always the echo of an earlier pixel beat, sent through the front end, the cells and the back end.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, QBITS + 2))
    else $error("result without a matching pixel");
`endif

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the RGB to HSV pixel converter.
//
// An initial block fills a queue of pixels. A clocked driver presents them one
// beat at a time on start and the in_ ports, with a random idle gap before
// some pixels. A clocked monitor takes each out_valid beat and compares it
// field by field with the oldest predicted result. The prediction is worked
// out by a behavioural model of the conversion when the pixel beat is taken.

module tb;

  import rhc_pkg::*;

  // Hue angles in units of 1/64 degree, and the largest channel code.
  localparam int ANG_60    = 60 * 64;
  localparam int ANG_120   = 120 * 64;
  localparam int ANG_240   = 240 * 64;
  localparam int ANG_360   = 360 * 64;
  localparam int CHAN_TOP  = 255;

  // Cycles with no beat on either side before the run is abandoned. The
  // longest legitimate quiet spell is the longest idle gap before a pixel,
  // or the pipeline draining while the sender waits.
  localparam int QUIET_LIMIT = 1000;
  // Cycles allowed after the last result for any stray beat to show itself.
  localparam int TAIL_CYCLES = 30;
  localparam int RANDOM_PIXELS = 400;
  // Pixels at the end of the random part that are sent back to back.
  localparam int DENSE_TAIL = 60;

  typedef struct {
    logic [CB-1:0] red;
    logic [CB-1:0] green;
    logic [CB-1:0] blue;
    int            gap;
  } pixel_t;

  typedef struct {
    logic [HUE_W-1:0] hue;
    logic [CB-1:0]    sat;
    logic [CB-1:0]    bright;
  } hsv_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [CB-1:0] in_red = '0;
  logic [CB-1:0] in_green = '0;
  logic [CB-1:0] in_blue = '0;
  logic busy;
  logic out_valid;
  logic [HUE_W-1:0] out_hue;
  logic [CB-1:0] out_saturation;
  logic [CB-1:0] out_brightness;

  pixel_t pixels_to_send[$];
  hsv_t   hsv_awaited[$];

  int mismatches = 0;
  int pixels_taken = 0;
  int results_checked = 0;
  int black_pixels = 0;
  int grey_pixels = 0;
  int wrapped_hues = 0;
  int quiet_cycles = 0;

  // Driver bookkeeping: the idle cycles still to wait before the head pixel.
  int  gap_left = 0;
  bit  gap_loaded = 1'b0;

  rgb_to_hsv_convert dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_brightness (out_brightness)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Behavioural conversion of one pixel. The channel holding the maximum picks
  // the sector, red first and then green, so ties go the same way as in the
  // block. Signed integer division truncates towards zero, which is what the
  // hue term needs; a negative angle wraps once round the circle.
  function automatic hsv_t hsv_of_pixel(input logic [CB-1:0] r, input logic [CB-1:0] g,
                                        input logic [CB-1:0] b);
    int rv;
    int gv;
    int bv;
    int hi;
    int lo;
    int span;
    int ang;
    int sat;
    hsv_t res;
    rv = r;
    gv = g;
    bv = b;
    hi = rv;
    lo = rv;
    if (gv > hi) hi = gv;
    if (bv > hi) hi = bv;
    if (gv < lo) lo = gv;
    if (bv < lo) lo = bv;
    span = hi - lo;
    ang = 0;
    sat = 0;
    if (hi != 0) begin
      sat = (span * CHAN_TOP) / hi;
      if (span != 0) begin
        if (rv == hi) begin
          ang = ((gv - bv) * ANG_60) / span;
        end else if (gv == hi) begin
          ang = ANG_120 + ((bv - rv) * ANG_60) / span;
        end else begin
          ang = ANG_240 + ((rv - gv) * ANG_60) / span;
        end
        if (ang < 0) ang += ANG_360;
      end
    end
    res.hue = ang[HUE_W-1:0];
    res.sat = sat[CB-1:0];
    res.bright = hi[CB-1:0];
    return res;
  endfunction

  // One line per wrong field, and the count goes up by one.
  task automatic report_mismatch(input string field, input int got, input int want);
    mismatches++;
    $display("%0t: %s is %0d, expected %0d", $realtime, field, got, want);
  endtask

  task automatic queue_pixel(input int r, input int g, input int b, input int gap);
    pixel_t p;
    p.red = r[CB-1:0];
    p.green = g[CB-1:0];
    p.blue = b[CB-1:0];
    p.gap = gap;
    pixels_to_send.push_back(p);
  endtask

  // Driver. A pixel beat is taken at an edge where start is high and busy is
  // low; the values seen here are those from before the edge, so the taken
  // beat is exactly what the block saw. The prediction is queued at once.
  // Start is assigned once per edge, so a pixel that follows straight on
  // keeps start high without a glitch.
  always @(posedge clk) begin
    logic next_start;
    hsv_t want;
    next_start = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        want = hsv_of_pixel(in_red, in_green, in_blue);
        hsv_awaited.push_back(want);
        pixels_taken++;
        if (want.bright == 0) black_pixels++;
        else if (want.sat == 0) grey_pixels++;
        if (want.hue > (in_red == want.bright ? ANG_60 : ANG_360)) wrapped_hues++;
        void'(pixels_to_send.pop_front());
        gap_loaded = 1'b0;
      end
      if (pixels_to_send.size() > 0) begin
        if (!gap_loaded) begin
          gap_left = pixels_to_send[0].gap;
          gap_loaded = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          next_start = 1'b1;
          in_red <= pixels_to_send[0].red;
          in_green <= pixels_to_send[0].green;
          in_blue <= pixels_to_send[0].blue;
        end
      end
      start <= next_start;
    end
  end

  // Monitor. Every out_valid beat must meet a waiting prediction; the block
  // cannot be held off, so each beat is taken in the cycle it is shown.
  always @(posedge clk) begin
    hsv_t want;
    if (rst_n && out_valid) begin
      if (hsv_awaited.size() == 0) begin
        report_mismatch("unexpected result beat, hue", out_hue, -1);
      end else begin
        want = hsv_awaited.pop_front();
        results_checked++;
        if (out_hue !== want.hue) report_mismatch("hue", out_hue, want.hue);
        if (out_saturation !== want.sat) report_mismatch("saturation", out_saturation, want.sat);
        if (out_brightness !== want.bright) begin
          report_mismatch("brightness", out_brightness, want.bright);
        end
      end
    end
  end

  // Watchdog: counts edges at which neither a pixel beat nor a result beat
  // is taken, and abandons the run if the count reaches its limit.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results still awaited", $realtime,
               QUIET_LIMIT, hsv_awaited.size());
      $display("rgb_to_hsv_convert: mismatch");
      $finish;
    end
  end

  initial begin
    int r;
    int g;
    int b;
    int flavour;
    int gap;
    bit idling;
    idling = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pixels, queued between edges so that the driver never sees
    // the queue change while it is working on it.
    @(negedge clk);
    queue_pixel(0, 0, 0, 0);         // black
    queue_pixel(255, 255, 255, 0);   // white, a grey of full brightness
    queue_pixel(128, 128, 128, 0);   // mid grey
    queue_pixel(1, 1, 1, 0);         // darkest grey
    queue_pixel(255, 0, 0, 0);       // pure red
    queue_pixel(0, 255, 0, 0);       // pure green
    queue_pixel(0, 0, 255, 3);       // pure blue
    queue_pixel(200, 200, 10, 0);    // red and green tie: red sector
    queue_pixel(200, 10, 200, 0);    // red and blue tie: red sector, wraps
    queue_pixel(10, 200, 200, 16);   // green and blue tie: green sector
    queue_pixel(255, 0, 128, 0);     // red sector, negative angle wraps
    queue_pixel(255, 0, 1, 0);       // smallest negative angle in red sector
    queue_pixel(255, 1, 0, 0);       // smallest positive angle in red sector
    queue_pixel(10, 255, 0, 1);      // green sector, angle below 120 degrees
    queue_pixel(0, 255, 10, 0);      // green sector, angle above 120 degrees
    queue_pixel(0, 10, 255, 0);      // blue sector, angle below 240 degrees
    queue_pixel(10, 0, 255, 0);      // blue sector, angle above 240 degrees
    queue_pixel(0, 0, 1, 0);         // dimmest blue
    queue_pixel(1, 0, 0, 0);         // dimmest red
    queue_pixel(254, 255, 0, 0);     // yellow just on the green side
    queue_pixel(255, 254, 253, 2);   // nearly grey, low saturation
    queue_pixel(0, 255, 255, 0);     // cyan
    queue_pixel(85, 170, 255, 0);    // blue sector with a mixed colour

    // Hold the sender back until every directed result has come out, so the
    // pipeline is seen to drain fully before the random part begins.
    while (pixels_to_send.size() != 0 || hsv_awaited.size() != 0) @(negedge clk);

    // Random pixels: half are uniform, some are very dim, some carry exact
    // ties between channels and some lie a few codes away from grey. Idling
    // is switched on and off in stretches and is absent at the very end.
    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      r = $urandom_range(0, CHAN_TOP);
      g = $urandom_range(0, CHAN_TOP);
      b = $urandom_range(0, CHAN_TOP);
      flavour = $urandom_range(0, 9);
      if (flavour < 2) begin
        r = r % 8;
        g = g % 8;
        b = b % 8;
      end else if (flavour < 4) begin
        case ($urandom_range(0, 2))
          0: g = r;
          1: b = r;
          default: b = g;
        endcase
      end else if (flavour == 4) begin
        g = r ^ $urandom_range(0, 3);
        b = r ^ $urandom_range(0, 3);
      end
      if (i % 50 == 0) idling = ($urandom_range(0, 2) != 0);
      gap = 0;
      if (idling && i < RANDOM_PIXELS - DENSE_TAIL && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 16);
      end
      queue_pixel(r, g, b, gap);
    end

    // Wait for every pixel to be taken and every result to arrive, then a
    // short tail in which any extra result beat would be caught.
    while (pixels_to_send.size() != 0 || hsv_awaited.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Converted %0d pixels and checked %0d results.", pixels_taken, results_checked);
    $display("Among them %0d black, %0d grey and %0d with a wrapped hue; %0d wrong fields.",
             black_pixels, grey_pixels, wrapped_hues, mismatches);
    if (mismatches == 0) begin
      $display("rgb_to_hsv_convert: match");
    end else begin
      $display("rgb_to_hsv_convert: mismatch");
    end
    $finish;
  end

endmodule
